// File: sv/flash_program_read_erase_regs_defines.svh
// Assertion helpers used by the checker file.
`ifndef FLASH_PROGRAM_READ_ERASE_REGS_DEFINES_SVH
`define FLASH_PROGRAM_READ_ERASE_REGS_DEFINES_SVH

// Same-cycle implication, quiet while reset is asserted.
`define FPRE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication, quiet while reset is asserted.
`define FPRE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// File: sv/fpre_pkg.sv
`default_nettype none

package fpre_pkg;

  // Register window offsets.
  localparam logic [7:0] OFF_CTRL   = 8'h00;
  localparam logic [7:0] OFF_ADDR   = 8'h04;
  localparam logic [7:0] OFF_LEN    = 8'h08;
  localparam logic [7:0] OFF_STATUS = 8'h0C;
  localparam logic [7:0] OFF_DATA   = 8'h10;

  // Operation codes in the control register.
  localparam logic [3:0] OP_PROGRAM = 4'd1;
  localparam logic [3:0] OP_READ    = 4'd2;
  localparam logic [3:0] OP_ERASE   = 4'd3;

  localparam int unsigned CTRL_START_BIT = 8;

  // Status bit positions and the write-one-to-clear mask.
  localparam int unsigned STAT_BUSY  = 0;
  localparam int unsigned STAT_DONE  = 1;
  localparam logic [2:0]  STATUS_W1C = 3'b110;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_SEEK,
    S_SWEEP,
    S_MEMRD,
    S_MEMWR,
    S_RESP
  } fpre_state_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic seek;
    logic sweep_start;
    logic sweep;
    logic clear;
    logic rd_capture;
    logic mem_wr;
    logic out_load;
  } fpre_cmd_t;

  typedef struct packed {
    logic erase_go;
    logic mem_rd;
    logic mem_wr;
    logic seek_done;
    logic seek_hit;
    logic sweep_last;
    logic clear_last;
    logic out_free;
  } fpre_sts_t;

endpackage

`default_nettype wire

// File: sv/fpre_req_if.sv
`default_nettype none

interface fpre_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;

  modport source (output valid, output mode, output reg_offset, output write_data,
                  input ready);
  modport sink (input valid, input mode, input reg_offset, input write_data,
                output ready);
endinterface

`default_nettype wire

// File: sv/fpre_rsp_if.sv
`default_nettype none

interface fpre_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        done_pulse;

  modport source (output valid, output read_data, output done_pulse, input ready);
  modport sink (input valid, input read_data, input done_pulse, output ready);
endinterface

`default_nettype wire

// File: sv/fpre_ctrl.sv
`default_nettype none

module fpre_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                req_valid_i,
  output logic                req_ready_o,
  input  fpre_pkg::fpre_sts_t sts_i,
  output fpre_pkg::fpre_cmd_t cmd_o
);

  fpre_pkg::fpre_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fpre_pkg::S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      fpre_pkg::S_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (sts_i.clear_last) state_d = fpre_pkg::S_IDLE;
      end
      fpre_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = fpre_pkg::S_EXEC;
        end
      end
      fpre_pkg::S_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.erase_go) begin
          state_d = fpre_pkg::S_SEEK;
        end else if (sts_i.mem_rd) begin
          state_d = fpre_pkg::S_MEMRD;
        end else if (sts_i.mem_wr) begin
          state_d = fpre_pkg::S_MEMWR;
        end else begin
          state_d = fpre_pkg::S_RESP;
        end
      end
      fpre_pkg::S_SEEK: begin
        // One sector is checked per cycle while no sector is being swept; sectors below the range are stepped over.
        if (sts_i.seek_done) begin
          state_d = fpre_pkg::S_RESP;
        end else if (sts_i.seek_hit) begin
          cmd_o.sweep_start = 1'b1;
          state_d           = fpre_pkg::S_SWEEP;
        end else begin
          cmd_o.seek = 1'b1;
        end
      end
      fpre_pkg::S_SWEEP: begin
        cmd_o.sweep = 1'b1;
        if (sts_i.sweep_last) state_d = fpre_pkg::S_SEEK;
      end
      fpre_pkg::S_MEMRD: begin
        cmd_o.rd_capture = 1'b1;
        state_d          = fpre_pkg::S_RESP;
      end
      fpre_pkg::S_MEMWR: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = fpre_pkg::S_RESP;
      end
      fpre_pkg::S_RESP: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = fpre_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = fpre_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// File: sv/fpre_datapath.sv
`default_nettype none

module fpre_datapath #(
  parameter int unsigned MEM_WORDS    = 4096,
  parameter int unsigned SECTOR_WORDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpre_pkg::fpre_cmd_t cmd_i,
  output fpre_pkg::fpre_sts_t sts_o,
  input  logic                req_mode_i,
  input  logic [7:0]          req_reg_offset_i,
  input  logic [31:0]         req_write_data_i,
  output logic                rsp_valid_o,
  input  logic                rsp_ready_i,
  output logic [31:0]         rsp_read_data_o,
  output logic                rsp_done_pulse_o
);

  localparam int unsigned AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int unsigned WW = (SECTOR_WORDS > 1) ? $clog2(SECTOR_WORDS) : 1;

  localparam logic [31:0]   MEM_LIMIT    = 32'(MEM_WORDS);
  localparam logic [31:0]   MEM_BYTES    = 32'(MEM_WORDS * 4);
  localparam logic [31:0]   SECTOR_BYTES = 32'(SECTOR_WORDS * 4);
  localparam logic [WW-1:0] WORD_LAST    = WW'(SECTOR_WORDS - 1);
  localparam logic [AW-1:0] MEM_LAST     = AW'(MEM_WORDS - 1);

  // Captured bus word.
  logic        mode_q;
  logic [7:0]  off_q;
  logic [31:0] wdata_q;

  // Architectural registers.
  logic [3:0]  op_q, op_d;
  logic [31:0] fl_addr_q, fl_addr_d;
  logic [31:0] len_q, len_d;
  logic [2:0]  status_q, status_d;
  logic [31:0] wc_q, wc_d;
  logic [30:0] we_q, we_d;

  logic [31:0] res_data_q, res_data_d;
  logic        res_pulse_q, res_pulse_d;

  logic [AW-1:0] idx_q;
  logic [31:0]   mem_q;
  logic [31:0]   mem [MEM_WORDS];

  // Erase sector scan: byte base of the sector under test and last byte of the range.
  logic [31:0]   base_q;
  logic [31:0]   end_q;
  logic [31:0]   base_next;
  logic          sec_fits;
  logic [WW-1:0] wsec_q;
  logic [AW-1:0] sweep_addr_q;

  logic        rsp_valid_q;
  logic [31:0] rsp_data_q;
  logic        rsp_pulse_q;

  logic [31:0] idx_full;
  logic        in_range;
  logic        busy;
  logic [30:0] words_from_len;
  logic [31:0] wc_inc;
  logic        stream_end;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [31:0]   mem_wdata;

  assign idx_full       = {2'b00, fl_addr_q[31:2]} + wc_q;
  assign in_range       = idx_full < MEM_LIMIT;
  assign busy           = status_q[fpre_pkg::STAT_BUSY];
  assign words_from_len = {1'b0, len_q[31:2]} + 31'(|len_q[1:0]);
  assign wc_inc         = wc_q + 32'd1;
  assign stream_end     = wc_inc >= {1'b0, we_q};

  assign sts_o.erase_go = mode_q && (off_q == fpre_pkg::OFF_CTRL)
                          && wdata_q[fpre_pkg::CTRL_START_BIT]
                          && (wdata_q[3:0] == fpre_pkg::OP_ERASE);
  assign sts_o.mem_rd   = !mode_q && (off_q == fpre_pkg::OFF_DATA) && busy
                          && (op_q == fpre_pkg::OP_READ) && in_range;
  assign sts_o.mem_wr   = mode_q && (off_q == fpre_pkg::OFF_DATA) && busy
                          && (op_q == fpre_pkg::OP_PROGRAM) && in_range;

  // Access decode and register update for one bus word.
  always_comb begin
    op_d        = op_q;
    fl_addr_d   = fl_addr_q;
    len_d       = len_q;
    status_d    = status_q;
    wc_d        = wc_q;
    we_d        = we_q;
    res_data_d  = res_data_q;
    res_pulse_d = res_pulse_q;
    if (cmd_i.exec) begin
      res_data_d  = '0;
      res_pulse_d = 1'b0;
      if (mode_q) begin
        case (off_q)
          fpre_pkg::OFF_CTRL: begin
            op_d = wdata_q[3:0];
            if (wdata_q[fpre_pkg::CTRL_START_BIT]) begin
              wc_d = '0;
              we_d = words_from_len;
              if (wdata_q[3:0] == fpre_pkg::OP_ERASE) begin
                status_d[fpre_pkg::STAT_BUSY] = 1'b0;
                status_d[fpre_pkg::STAT_DONE] = 1'b1;
                res_pulse_d = 1'b1;
              end else if (wdata_q[3:0] == fpre_pkg::OP_PROGRAM ||
                           wdata_q[3:0] == fpre_pkg::OP_READ) begin
                status_d[fpre_pkg::STAT_BUSY] = 1'b1;
                status_d[fpre_pkg::STAT_DONE] = 1'b0;
                if (words_from_len == '0) begin
                  status_d[fpre_pkg::STAT_BUSY] = 1'b0;
                  status_d[fpre_pkg::STAT_DONE] = 1'b1;
                  res_pulse_d = 1'b1;
                end
              end
            end
          end
          fpre_pkg::OFF_ADDR:   fl_addr_d = wdata_q;
          fpre_pkg::OFF_LEN:    len_d = wdata_q;
          fpre_pkg::OFF_STATUS: status_d = status_q & ~(wdata_q[2:0] & fpre_pkg::STATUS_W1C);
          fpre_pkg::OFF_DATA: begin
            if (busy && op_q == fpre_pkg::OP_PROGRAM) begin
              wc_d = wc_inc;
              if (stream_end) begin
                status_d[fpre_pkg::STAT_BUSY] = 1'b0;
                status_d[fpre_pkg::STAT_DONE] = 1'b1;
                res_pulse_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end else begin
        case (off_q)
          fpre_pkg::OFF_CTRL:   res_data_d = {28'd0, op_q};
          fpre_pkg::OFF_ADDR:   res_data_d = fl_addr_q;
          fpre_pkg::OFF_LEN:    res_data_d = len_q;
          fpre_pkg::OFF_STATUS: res_data_d = {29'd0, status_q};
          fpre_pkg::OFF_DATA: begin
            if (busy && op_q == fpre_pkg::OP_READ) begin
              // Out-of-range reads return all ones; in range, the stored word
              // replaces this one in the read-capture state that follows.
              res_data_d = fpre_pkg::ALL_ONES;
              wc_d       = wc_inc;
              if (stream_end) begin
                status_d[fpre_pkg::STAT_BUSY] = 1'b0;
                status_d[fpre_pkg::STAT_DONE] = 1'b1;
                res_pulse_d = 1'b1;
              end
            end
          end
          default: ;
        endcase
      end
    end else if (cmd_i.rd_capture) begin
      res_data_d = mem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q      <= '0;
      fl_addr_q <= '0;
      len_q     <= '0;
      status_q  <= '0;
      wc_q      <= '0;
      we_q      <= '0;
    end else begin
      op_q      <= op_d;
      fl_addr_q <= fl_addr_d;
      len_q     <= len_d;
      status_q  <= status_d;
      wc_q      <= wc_d;
      we_q      <= we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q  <= req_mode_i;
      off_q   <= req_reg_offset_i;
      wdata_q <= req_write_data_i;
    end
    if (cmd_i.exec) idx_q <= idx_full[AW-1:0];
    res_data_q  <= res_data_d;
    res_pulse_q <= res_pulse_d;
  end

  // Sectors are tested in order from the bottom of the store. A sector is erased when it
  // ends above the start address and begins at or below the wrapped end address; the scan
  // stops at the first sector past the range or not wholly inside the store.
  assign base_next        = base_q + SECTOR_BYTES;
  assign sec_fits         = base_next <= MEM_BYTES;
  assign sts_o.seek_done  = !sec_fits || (base_q > end_q);
  assign sts_o.seek_hit   = base_next > fl_addr_q;
  assign sts_o.sweep_last = wsec_q == WORD_LAST;
  assign sts_o.clear_last = sweep_addr_q == MEM_LAST;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      end_q  <= '0;
    end else if (cmd_i.exec) begin
      base_q <= '0;
      end_q  <= fl_addr_q + len_q - 32'd1;
    end else if (cmd_i.seek || (cmd_i.sweep && wsec_q == WORD_LAST)) begin
      base_q <= base_next;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_addr_q <= '0;
      wsec_q       <= '0;
    end else if (cmd_i.sweep_start) begin
      sweep_addr_q <= base_q[AW+1:2];
      wsec_q       <= '0;
    end else if (cmd_i.sweep) begin
      sweep_addr_q <= sweep_addr_q + AW'(1);
      if (wsec_q == WORD_LAST) begin
        wsec_q <= '0;
      end else begin
        wsec_q <= wsec_q + WW'(1);
      end
    end else if (cmd_i.clear) begin
      sweep_addr_q <= sweep_addr_q + AW'(1);
    end
  end

  assign mem_we    = cmd_i.sweep | cmd_i.clear | cmd_i.mem_wr;
  assign mem_waddr = cmd_i.mem_wr ? idx_q : sweep_addr_q;
  assign mem_wdata = cmd_i.mem_wr ? (mem_q & wdata_q) : fpre_pkg::ALL_ONES;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (cmd_i.exec) mem_q <= mem[idx_full[AW-1:0]];
  end

  // Output register.
  assign sts_o.out_free = !rsp_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      rsp_data_q  <= res_data_q;
      rsp_pulse_q <= res_pulse_q;
    end
  end

  assign rsp_valid_o      = rsp_valid_q;
  assign rsp_read_data_o  = rsp_data_q;
  assign rsp_done_pulse_o = rsp_pulse_q;

endmodule

`default_nettype wire

// File: sv/flash_program_read_erase_regs.sv
// Flash register window with program, read and erase. Each request word is one bus access
// (control, address, length, status or data port) and yields exactly one response word.
// After reset the store is swept to all ones, one word per cycle, and no request is taken
// until the sweep ends. A register access is captured on acceptance, decoded and applied
// in the execute state and loaded into the output register in the response state, after
// which the block returns to idle for the next word. A data-port access that hits the store
// passes through a further state, since the word read from the array at decode is captured
// (or, for programming, ANDed with the write data and written back) in the state after it.
// An erase start tests sectors against the range one per cycle from the store's bottom,
// pausing while each sector in range is filled one word per cycle. A response that waits on
// a busy sink holds the block in the response state. One access is in flight at a time.
`default_nettype none

module flash_program_read_erase_regs #(
  parameter int unsigned MEM_WORDS    = 4096,
  parameter int unsigned SECTOR_WORDS = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  fpre_req_if.sink     bus_req_i,
  fpre_rsp_if.source   bus_rsp_o
);

  fpre_pkg::fpre_cmd_t cmd;
  fpre_pkg::fpre_sts_t sts;

  fpre_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (bus_req_i.valid),
    .req_ready_o (bus_req_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  fpre_datapath #(
    .MEM_WORDS    (MEM_WORDS),
    .SECTOR_WORDS (SECTOR_WORDS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .req_mode_i       (bus_req_i.mode),
    .req_reg_offset_i (bus_req_i.reg_offset),
    .req_write_data_i (bus_req_i.write_data),
    .rsp_valid_o      (bus_rsp_o.valid),
    .rsp_ready_i      (bus_rsp_o.ready),
    .rsp_read_data_o  (bus_rsp_o.read_data),
    .rsp_done_pulse_o (bus_rsp_o.done_pulse)
  );

endmodule

`default_nettype wire

// File: sv/fpre_checker.sv
`default_nettype none
`include "flash_program_read_erase_regs_defines.svh"

module fpre_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_read_data_i,
  input logic        rsp_done_pulse_i
);

  // Only one access is in flight, so an accepted word closes the request side.
  `FPRE_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, req_valid_i && req_ready_i, !req_ready_i)

  // A new response appears exactly when the block reopens for the next word.
  `FPRE_ASSERT_IMP(a_rsp_reopens, clk_i, rst_ni, $rose(rsp_valid_i), req_ready_i)

  `FPRE_ASSERT_NXT(a_rsp_held, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, rsp_valid_i)

  `FPRE_ASSERT_NXT(a_rsp_stable, clk_i, rst_ni, rsp_valid_i && !rsp_ready_i, $stable(rsp_read_data_i) && $stable(rsp_done_pulse_i))

endmodule

bind flash_program_read_erase_regs fpre_checker u_fpre_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (bus_req_i.valid),
  .req_ready_i      (bus_req_i.ready),
  .rsp_valid_i      (bus_rsp_o.valid),
  .rsp_ready_i      (bus_rsp_o.ready),
  .rsp_read_data_i  (bus_rsp_o.read_data),
  .rsp_done_pulse_i (bus_rsp_o.done_pulse)
);

`default_nettype wire

// File: verif/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MEM_WORDS    = 4096;
  localparam int unsigned SECTOR_WORDS = 1024;
  localparam int unsigned NUM_SECTORS  = MEM_WORDS / SECTOR_WORDS;
  localparam int unsigned ITEM_TARGET  = 550;
  localparam int unsigned STALL_LIMIT  = 20000;

  // Scoreboard: mirrors the register window and the flash array, and keeps the
  // replies that the block still owes, oldest first.
  class flash_access_scoreboard;
    typedef struct packed {
      logic [31:0] read_data;
      logic        done_pulse;
    } reply_t;

    reply_t      pending_replies[$];
    logic [3:0]  op_code;
    logic [31:0] flash_addr;
    logic [31:0] byte_len;
    logic [2:0]  status;
    logic [31:0] word_count;
    logic [30:0] words_due;
    logic [31:0] flash_words[MEM_WORDS];
    int unsigned errors;
    int unsigned accesses;
    int unsigned mapped_accesses;
    int unsigned erase_starts;
    int unsigned stream_words;
    int unsigned done_pulses;

    function new();
      op_code    = '0;
      flash_addr = '0;
      byte_len   = '0;
      status     = '0;
      word_count = '0;
      words_due  = '0;
      foreach (flash_words[i]) flash_words[i] = fpre_pkg::ALL_ONES;
    endfunction

    task report_mismatch(input string what);
      $display("MISMATCH at %0t ns: %s", $time, what);
      errors++;
    endtask

    function void finish_op();
      status[fpre_pkg::STAT_BUSY] = 1'b0;
      status[fpre_pkg::STAT_DONE] = 1'b1;
    endfunction

    function void erase_sectors();
      longint unsigned sector_bytes;
      longint unsigned first_sector;
      longint unsigned last_sector;
      longint unsigned s;
      logic [31:0]     end_byte;
      sector_bytes = longint'(SECTOR_WORDS) * 4;
      // The end address wraps at 32 bits, so a zero length covers the whole store only
      // when the start address is zero.
      end_byte     = flash_addr + byte_len - 32'd1;
      first_sector = flash_addr / sector_bytes;
      last_sector  = end_byte / sector_bytes;
      if (last_sector > NUM_SECTORS - 1) last_sector = NUM_SECTORS - 1;
      for (s = first_sector; s <= last_sector; s++) begin
        for (int w = 0; w < SECTOR_WORDS; w++)
          flash_words[s * SECTOR_WORDS + w] = fpre_pkg::ALL_ONES;
      end
    endfunction

    function logic advance_stream();
      word_count = word_count + 32'd1;
      stream_words++;
      if (word_count >= {1'b0, words_due}) begin
        finish_op();
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void predict_access(input logic write_access, input logic [7:0] off,
                                 input logic [31:0] data);
      logic [31:0] rd;
      logic        pulse;
      logic [31:0] idx;
      rd    = '0;
      pulse = 1'b0;
      idx   = (flash_addr >> 2) + word_count;
      accesses++;
      if (off inside {fpre_pkg::OFF_CTRL, fpre_pkg::OFF_ADDR, fpre_pkg::OFF_LEN,
                      fpre_pkg::OFF_STATUS, fpre_pkg::OFF_DATA}) mapped_accesses++;
      if (write_access) begin
        case (off)
          fpre_pkg::OFF_CTRL: begin
            op_code = data[3:0];
            if (data[fpre_pkg::CTRL_START_BIT]) begin
              word_count = '0;
              words_due  = 31'((byte_len >> 2) + (byte_len[1:0] != 2'b00));
              if (op_code == fpre_pkg::OP_ERASE) begin
                erase_sectors();
                finish_op();
                pulse = 1'b1;
                erase_starts++;
              end else if (op_code == fpre_pkg::OP_PROGRAM || op_code == fpre_pkg::OP_READ) begin
                status[fpre_pkg::STAT_BUSY] = 1'b1;
                status[fpre_pkg::STAT_DONE] = 1'b0;
                if (words_due == '0) begin
                  finish_op();
                  pulse = 1'b1;
                end
              end
            end
          end
          fpre_pkg::OFF_ADDR:   flash_addr = data;
          fpre_pkg::OFF_LEN:    byte_len = data;
          fpre_pkg::OFF_STATUS: status = status & ~(data[2:0] & fpre_pkg::STATUS_W1C);
          fpre_pkg::OFF_DATA: begin
            if (status[fpre_pkg::STAT_BUSY] && op_code == fpre_pkg::OP_PROGRAM) begin
              if (idx < MEM_WORDS) flash_words[idx] = flash_words[idx] & data;
              pulse = advance_stream();
            end
          end
          default: ;
        endcase
      end else begin
        case (off)
          fpre_pkg::OFF_CTRL:   rd = {28'b0, op_code};
          fpre_pkg::OFF_ADDR:   rd = flash_addr;
          fpre_pkg::OFF_LEN:    rd = byte_len;
          fpre_pkg::OFF_STATUS: rd = {29'b0, status};
          fpre_pkg::OFF_DATA: begin
            if (status[fpre_pkg::STAT_BUSY] && op_code == fpre_pkg::OP_READ) begin
              rd    = (idx < MEM_WORDS) ? flash_words[idx] : fpre_pkg::ALL_ONES;
              pulse = advance_stream();
            end
          end
          default: ;
        endcase
      end
      if (pulse) done_pulses++;
      pending_replies.push_back('{read_data: rd, done_pulse: pulse});
    endfunction

    task check_reply(input logic [31:0] rd, input logic pulse);
      reply_t want;
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("reply %h/%b with no access outstanding", rd, pulse));
      end else begin
        want = pending_replies.pop_front();
        if (rd !== want.read_data)
          report_mismatch($sformatf("read_data %h, expected %h", rd, want.read_data));
        if (pulse !== want.done_pulse)
          report_mismatch($sformatf("done_pulse %b, expected %b", pulse, want.done_pulse));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  logic steady;
  int unsigned sent;
  int unsigned quiet_cycles;

  fpre_req_if bus_req();
  fpre_rsp_if bus_rsp();

  flash_access_scoreboard sb = new();

  flash_program_read_erase_regs #(
    .MEM_WORDS   (MEM_WORDS),
    .SECTOR_WORDS(SECTOR_WORDS)
  ) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .bus_req_i(bus_req),
    .bus_rsp_o(bus_rsp)
  );

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Drives one request word and returns once it has been taken. Valid stays high
  // after the handshake, so back-to-back words keep it asserted between them.
  task automatic drive_word(input logic write_access, input logic [7:0] off,
                            input logic [31:0] data);
    if (!steady && $urandom_range(99) < 38) begin
      bus_req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    bus_req.valid      <= 1'b1;
    bus_req.mode       <= write_access;
    bus_req.reg_offset <= off;
    bus_req.write_data <= data;
    @(posedge clk_i);
    while (!bus_req.ready) @(posedge clk_i);
    sb.predict_access(write_access, off, data);
    sent++;
  endtask

  function automatic logic [31:0] pick_address();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 80) return 32'($urandom_range(0, MEM_WORDS - 1)) << 2;
    if (r < 90) return 32'($urandom_range(0, MEM_WORDS * 4 - 1));
    if (r < 95) return 32'(MEM_WORDS - $urandom_range(1, 4)) << 2;
    return $urandom();
  endfunction

  task automatic run_stream(input logic [3:0] op);
    logic [31:0] len;
    logic [31:0] cdata;
    logic [31:0] sdata;
    int unsigned words;
    len = ($urandom_range(99) < 95) ? $urandom_range(0, 40) : $urandom_range(41, 128);
    words = (len + 3) / 4;
    if ($urandom_range(99) < 10) words = $urandom_range(0, words);
    else if ($urandom_range(99) < 10) words++;
    cdata = $urandom();
    cdata[3:0] = op;
    cdata[fpre_pkg::CTRL_START_BIT] = 1'b1;
    drive_word(1'b1, fpre_pkg::OFF_ADDR, pick_address());
    drive_word(1'b1, fpre_pkg::OFF_LEN, len);
    drive_word(1'b1, fpre_pkg::OFF_CTRL, cdata);
    for (int i = 0; i < words; i++) begin
      if ($urandom_range(99) < 5) drive_word(1'b0, fpre_pkg::OFF_STATUS, $urandom());
      // Switching the operation mid-stream redirects the data port.
      if ($urandom_range(99) < 3) begin
        sdata = $urandom();
        sdata[3:0] = ($urandom_range(1) != 0) ? fpre_pkg::OP_PROGRAM : fpre_pkg::OP_READ;
        sdata[fpre_pkg::CTRL_START_BIT] = 1'b0;
        drive_word(1'b1, fpre_pkg::OFF_CTRL, sdata);
        op = sdata[3:0];
      end
      drive_word(op == fpre_pkg::OP_PROGRAM, fpre_pkg::OFF_DATA, $urandom());
    end
    if ($urandom_range(99) < 60) drive_word(1'b0, fpre_pkg::OFF_STATUS, $urandom());
    if ($urandom_range(99) < 50) drive_word(1'b1, fpre_pkg::OFF_STATUS, $urandom());
  endtask

  task automatic run_erase();
    logic [31:0] cdata;
    int unsigned r;
    r = $urandom_range(99);
    cdata = $urandom();
    cdata[3:0] = fpre_pkg::OP_ERASE;
    cdata[fpre_pkg::CTRL_START_BIT] = 1'b1;
    drive_word(1'b1, fpre_pkg::OFF_ADDR, pick_address());
    if (r < 70) drive_word(1'b1, fpre_pkg::OFF_LEN, $urandom_range(1, SECTOR_WORDS * 8));
    else if (r < 90) drive_word(1'b1, fpre_pkg::OFF_LEN, $urandom_range(0, 16));
    else drive_word(1'b1, fpre_pkg::OFF_LEN, $urandom());
    drive_word(1'b1, fpre_pkg::OFF_CTRL, cdata);
    if ($urandom_range(99) < 50) drive_word(1'b0, fpre_pkg::OFF_STATUS, $urandom());
  endtask

  task automatic run_noise();
    logic [7:0] off;
    int unsigned count;
    count = $urandom_range(1, 4);
    repeat (count) begin
      case ($urandom_range(5))
        0: off = fpre_pkg::OFF_CTRL;
        1: off = fpre_pkg::OFF_ADDR;
        2: off = fpre_pkg::OFF_LEN;
        3: off = fpre_pkg::OFF_STATUS;
        4: off = fpre_pkg::OFF_DATA;
        default: off = 8'($urandom_range(0, 255));
      endcase
      if ($urandom_range(1) != 0) off = 8'($urandom_range(0, 255));
      drive_word($urandom_range(1) != 0, off, $urandom());
    end
  endtask

  // Response side: ready idles at random outside the steady stretch.
  initial begin
    bus_rsp.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && bus_rsp.valid && bus_rsp.ready)
        sb.check_reply(bus_rsp.read_data, bus_rsp.done_pulse);
      bus_rsp.ready <= steady || ($urandom_range(99) >= 38);
    end
  end

  // Ends a run that stops moving words in either direction.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((bus_req.valid && bus_req.ready) || (bus_rsp.valid && bus_rsp.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned pick;
    steady = 1'b0;
    sent   = 0;
    rst_ni             <= 1'b0;
    bus_req.valid      <= 1'b0;
    bus_req.mode       <= 1'b0;
    bus_req.reg_offset <= '0;
    bus_req.write_data <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The program stream straddles the first sector boundary and is
    // switched to a read before its last word.
    drive_word(1'b0, fpre_pkg::OFF_CTRL, fpre_pkg::ALL_ONES);
    drive_word(1'b1, fpre_pkg::OFF_ADDR, 32'h0000_0FFC);
    drive_word(1'b1, fpre_pkg::OFF_LEN, 32'd5);
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_PROGRAM) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    drive_word(1'b1, fpre_pkg::OFF_DATA, 32'h0000_0000);
    drive_word(1'b1, fpre_pkg::OFF_CTRL, 32'(fpre_pkg::OP_READ));
    drive_word(1'b0, fpre_pkg::OFF_DATA, 32'h0);
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_READ) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    drive_word(1'b0, fpre_pkg::OFF_DATA, fpre_pkg::ALL_ONES);
    drive_word(1'b0, fpre_pkg::OFF_DATA, 32'h0);
    drive_word(1'b0, fpre_pkg::OFF_STATUS, 32'h0);
    drive_word(1'b1, fpre_pkg::OFF_STATUS, fpre_pkg::ALL_ONES);
    drive_word(1'b0, fpre_pkg::OFF_DATA, 32'h0);
    drive_word(1'b1, fpre_pkg::OFF_ADDR, fpre_pkg::ALL_ONES - 32'd3);
    drive_word(1'b1, fpre_pkg::OFF_LEN, 32'd0);
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_READ) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    drive_word(1'b1, fpre_pkg::OFF_LEN, 32'd4);
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_READ) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    drive_word(1'b0, fpre_pkg::OFF_DATA, 32'h0);
    // Erase with the whole range beyond the end of the store, then an empty range.
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_ERASE) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    drive_word(1'b1, fpre_pkg::OFF_ADDR, 32'h0000_2000);
    drive_word(1'b1, fpre_pkg::OFF_LEN, 32'hFFFF_F000);
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_ERASE) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    // A zero length wraps the end address and erases the whole store.
    drive_word(1'b1, fpre_pkg::OFF_ADDR, 32'h0);
    drive_word(1'b1, fpre_pkg::OFF_LEN, 32'h0);
    drive_word(1'b1, fpre_pkg::OFF_CTRL,
               32'(fpre_pkg::OP_ERASE) | (32'd1 << fpre_pkg::CTRL_START_BIT));
    drive_word(1'b1, 8'h02, fpre_pkg::ALL_ONES);
    drive_word(1'b0, 8'hFF, 32'h0);

    while (sent < ITEM_TARGET) begin
      steady = (sent >= 250 && sent < 370);
      pick = $urandom_range(99);
      if (pick < 38) run_stream(fpre_pkg::OP_PROGRAM);
      else if (pick < 70) run_stream(fpre_pkg::OP_READ);
      else if (pick < 78) run_erase();
      else run_noise();
    end
    steady = 1'b0;
    bus_req.valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Covered %0d accesses (%0d to mapped registers): %0d erase starts,",
             sb.accesses, sb.mapped_accesses, sb.erase_starts);
    $display("%0d data-port stream words and %0d done pulses.",
             sb.stream_words, sb.done_pulses);
    if (sb.errors == 0 && sb.pending_replies.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
